// ===== rtl/core/ray_cube_face_select_top_macros.svh =====
// Assertion helpers for the face select block
`ifndef RAY_CUBE_FACE_SELECT_TOP_MACROS_SVH
`define RAY_CUBE_FACE_SELECT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RCFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rcfs_pkg.sv =====
`timescale 1ns / 1ps
package rcfs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QW            = 32;
    localparam int QB            = QW - 1;
    localparam int DIV_BPS       = 2;
    localparam int DIST_W        = 64;

    typedef enum logic [2:0] {
        FACE_TOP,
        FACE_BOTTOM,
        FACE_POS_X,
        FACE_NEG_X,
        FACE_POS_Z,
        FACE_NEG_Z
    } face_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] sq_dist;
    } cand_t;

    // 0 = x, 1 = y, 2 = z
    function automatic int axis_of(input int k);
        return (k < 2) ? 1 : ((k < 4) ? 0 : 2);
    endfunction

endpackage

// ===== rtl/core/rcfs_div.sv =====
`timescale 1ns / 1ps
module rcfs_div
    import rcfs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DW        = 34
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [DW-1:0] diff,
    input  logic signed [31:0]   dvs,
    output logic signed [QW-1:0] q
);

    localparam int NST = (QB + DIV_BPS - 1) / DIV_BPS;
    localparam int NW  = DW - 1 + FRAC_BITS;
    localparam int HW  = NW - QB;

    logic [DW-2:0] un;
    logic [31:0]   ud;
    logic          neg;
    logic [NW-1:0] num;
    logic [HW-1:0] rhi;
    logic          sat;

    logic [31:0]   rem_reg  [NST+1];
    logic [QB-1:0] nlow_reg [NST+1];
    logic [QB-1:0] quot_reg [NST+1];
    logic [31:0]   ud_reg   [NST+1];
    logic          neg_reg  [NST+1];
    logic          sat_reg  [NST+1];
    logic [QW-1:0] mag;
    logic signed [QW-1:0] q_reg;

    always_comb
    begin
        un  = diff[DW-1] ? (DW-1)'(-diff) : diff[DW-2:0];
        ud  = dvs[31] ? 32'(-dvs) : 32'(dvs);
        neg = diff[DW-1] ^ dvs[31];
        num = {un, {FRAC_BITS{1'b0}}};
        rhi = num[NW-1:QB];
        sat = ({{32{1'b0}}, rhi} >= {{HW{1'b0}}, ud});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= sat ? 32'd0 : 32'(rhi);
            nlow_reg[0] <= num[QB-1:0];
            quot_reg[0] <= '0;
            ud_reg[0]   <= ud;
            neg_reg[0]  <= neg;
            sat_reg[0]  <= sat;
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [31:0]   rem_next;
        logic [QB-1:0] nlow_next;
        logic [QB-1:0] quot_next;

        always_comb
        begin
            logic [32:0] t;
            rem_next  = rem_reg[s];
            nlow_next = nlow_reg[s];
            quot_next = quot_reg[s];
            for (int j = 0; j < DIV_BPS; j++)
            begin
                if (s * DIV_BPS + j < QB)
                begin
                    t         = {rem_next, nlow_next[QB-1]};
                    nlow_next = {nlow_next[QB-2:0], 1'b0};
                    if (t >= {1'b0, ud_reg[s]})
                    begin
                        rem_next  = 32'(t - {1'b0, ud_reg[s]});
                        quot_next = {quot_next[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = t[31:0];
                        quot_next = {quot_next[QB-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_next;
                nlow_reg[s+1] <= nlow_next;
                quot_reg[s+1] <= quot_next;
                ud_reg[s+1]   <= ud_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                sat_reg[s+1]  <= sat_reg[s];
            end
        end
    end

    assign mag = sat_reg[NST] ? {1'b0, {QB{1'b1}}} : {1'b0, quot_reg[NST]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= neg_reg[NST] ? -$signed(mag) : $signed(mag);
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/rcfs_face.sv =====
`timescale 1ns / 1ps
module rcfs_face
    import rcfs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DW        = 34,
    parameter int LW        = 32
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic                 skip,
    input  logic signed [QW-1:0] q,
    input  logic signed [DW-1:0] diff,
    input  logic signed [31:0]   ob,
    input  logic signed [31:0]   oc,
    input  logic signed [31:0]   db,
    input  logic signed [31:0]   dc,
    input  logic signed [LW-1:0] lob,
    input  logic signed [LW-1:0] loc,
    output cand_t                cand
);

    localparam logic signed [65:0] UNIT = 66'sd1 <<< FRAC_BITS;

    // F1
    logic signed [63:0]   prod_b_reg, prod_c_reg;
    logic [DIST_W-1:0]    sqd_reg;
    logic signed [31:0]   ob_reg, oc_reg;
    logic signed [LW-1:0] lob_reg, loc_reg;
    logic                 skip1_reg;
    logic [DW-1:0]        dabs;
    logic [DIST_W-1:0]    sqd_next;

    // F2
    logic signed [63:0]   off_b, off_c;
    logic [63:0]          mag_b, mag_c;
    logic signed [65:0]   c_b, c_c, lo_b, lo_c;
    logic [DIST_W-1:0]    sq_b_next, sq_c_next;
    logic                 inside_next;
    logic [DIST_W-1:0]    sq_b_reg, sq_c_reg, sqd2_reg;
    logic                 inside_reg, skip2_reg;

    // F3
    logic [DIST_W:0]      s1, s2;
    logic [DIST_W-1:0]    s1_sat, s2_sat;
    cand_t                cand_reg;

    always_comb
    begin
        dabs     = diff[DW-1] ? DW'(-diff) : DW'(diff);
        sqd_next = (|dabs[DW-1:32]) ? {DIST_W{1'b1}}
                                    : 64'(dabs[31:0]) * 64'(dabs[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_b_reg <= 64'(q) * 64'(db);
            prod_c_reg <= 64'(q) * 64'(dc);
            sqd_reg    <= sqd_next;
            ob_reg     <= ob;
            oc_reg     <= oc;
            lob_reg    <= lob;
            loc_reg    <= loc;
            skip1_reg  <= skip;
        end
    end

    always_comb
    begin
        off_b       = prod_b_reg >>> FRAC_BITS;
        off_c       = prod_c_reg >>> FRAC_BITS;
        mag_b       = off_b[63] ? 64'(-off_b) : 64'(off_b);
        mag_c       = off_c[63] ? 64'(-off_c) : 64'(off_c);
        c_b         = 66'(ob_reg) + 66'(off_b);
        c_c         = 66'(oc_reg) + 66'(off_c);
        lo_b        = 66'(lob_reg);
        lo_c        = 66'(loc_reg);
        inside_next = (c_b >= lo_b) && (c_b <= lo_b + UNIT)
                   && (c_c >= lo_c) && (c_c <= lo_c + UNIT);
        sq_b_next   = (|mag_b[63:32]) ? {DIST_W{1'b1}}
                                      : 64'(mag_b[31:0]) * 64'(mag_b[31:0]);
        sq_c_next   = (|mag_c[63:32]) ? {DIST_W{1'b1}}
                                      : 64'(mag_c[31:0]) * 64'(mag_c[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_b_reg   <= sq_b_next;
            sq_c_reg   <= sq_c_next;
            sqd2_reg   <= sqd_reg;
            inside_reg <= inside_next;
            skip2_reg  <= skip1_reg;
        end
    end

    always_comb
    begin
        s1     = {1'b0, sqd2_reg} + {1'b0, sq_b_reg};
        s1_sat = s1[DIST_W] ? {DIST_W{1'b1}} : s1[DIST_W-1:0];
        s2     = {1'b0, s1_sat} + {1'b0, sq_c_reg};
        s2_sat = s2[DIST_W] ? {DIST_W{1'b1}} : s2[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg.hit     <= !skip2_reg && inside_reg && (s2_sat != '0);
            cand_reg.sq_dist <= s2_sat;
        end
    end

    assign cand = cand_reg;

endmodule

// ===== rtl/core/rcfs_pick.sv =====
`timescale 1ns / 1ps
module rcfs_pick
    import rcfs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  cand_t cand [6],
    output face_t sel_face,
    output logic  sel_hit
);

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] sq_dist;
        face_t             idx;
    } win_t;

    // a carries the lower face index
    function automatic win_t better(input win_t a, input win_t b);
        return (a.hit && (!b.hit || a.sq_dist <= b.sq_dist)) ? a : b;
    endfunction

    win_t  lvl0 [6];
    win_t  w_reg [3];
    win_t  fin;
    face_t face_reg;
    logic  hit_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            lvl0[k].hit     = cand[k].hit;
            lvl0[k].sq_dist = cand[k].sq_dist;
            lvl0[k].idx     = face_t'(k);
        end
        fin = better(better(w_reg[0], w_reg[1]), w_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= better(lvl0[2*i], lvl0[2*i+1]);
            end
            face_reg <= fin.hit ? fin.idx : FACE_TOP;
            hit_reg  <= fin.hit;
        end
    end

    assign sel_face = face_reg;
    assign sel_hit  = hit_reg;

endmodule

// ===== rtl/core/ray_cube_face_select_top.sv =====
`timescale 1ns / 1ps
// channel | signals                                          | direction
// in      | in_valid, in_ready, origin_*, dir_*, cell_*      | ray transaction in
// out     | out_valid, out_ready, face, hit                  | face transaction out
//
// One transaction per cycle while the output is not stalled; the divider is
// ceil(31 / 2) stages of a pipelined restoring divider.
// rst_n clears the valid bits only.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module ray_cube_face_select_top
    import rcfs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [15:0] cell_x,
    input  logic signed [15:0] cell_y,
    input  logic signed [15:0] cell_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         face,
    output logic               hit
);

`include "ray_cube_face_select_top_macros.svh"

    localparam int DW   = (((17 + FRAC_BITS) > 32) ? (17 + FRAC_BITS) : 32) + 2;
    localparam int LW   = 16 + FRAC_BITS;
    localparam int NST  = (QB + DIV_BPS - 1) / DIV_BPS;
    localparam int LDIV = NST + 2;
    localparam int TOT  = LDIV + 6;
    localparam logic signed [DW-1:0] UNIT_D = DW'(1) << FRAC_BITS;

    typedef struct packed {
        logic [2:0][31:0]    o;
        logic [2:0][31:0]    d;
        logic [2:0][LW-1:0]  lo;
        logic [5:0][DW-1:0]  diff;
        logic [5:0]          skip;
    } pay_t;

    pay_t               pay_next;
    pay_t               pay_reg [LDIV+1];
    logic [TOT-1:0]     vld_reg;
    logic               en;
    logic signed [QW-1:0] q_w [6];
    cand_t              cand_w [6];
    face_t              sel_face;
    logic               sel_hit;

    assign en        = !vld_reg[TOT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[TOT-1];
    assign face      = sel_face;
    assign hit       = sel_hit;

    always_comb
    begin
        int a;
        logic signed [DW-1:0] lo_ext;
        logic signed [DW-1:0] plane;
        pay_next.o  = {origin_z, origin_y, origin_x};
        pay_next.d  = {dir_z, dir_y, dir_x};
        pay_next.lo = {{cell_z, {FRAC_BITS{1'b0}}},
                       {cell_y, {FRAC_BITS{1'b0}}},
                       {cell_x, {FRAC_BITS{1'b0}}}};
        for (int k = 0; k < 6; k++)
        begin
            a      = axis_of(k);
            lo_ext = DW'($signed(pay_next.lo[a]));
            plane  = (k % 2 == 1) ? lo_ext : lo_ext + UNIT_D;
            pay_next.diff[k] = plane - DW'($signed(pay_next.o[a]));
            pay_next.skip[k] = (pay_next.d[a] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= pay_next;
            for (int i = 1; i <= LDIV; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOT-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_face
        localparam int A = axis_of(k);
        localparam int B = (A == 0) ? 1 : 0;
        localparam int C = (A == 2) ? 1 : 2;

        rcfs_div #(
            .FRAC_BITS (FRAC_BITS),
            .DW        (DW)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .diff (pay_reg[0].diff[k]),
            .dvs  (pay_reg[0].d[A]),
            .q    (q_w[k])
        );

        rcfs_face #(
            .FRAC_BITS (FRAC_BITS),
            .DW        (DW),
            .LW        (LW)
        ) u_face (
            .clk  (clk),
            .en   (en),
            .skip (pay_reg[LDIV].skip[k]),
            .q    (q_w[k]),
            .diff (pay_reg[LDIV].diff[k]),
            .ob   (pay_reg[LDIV].o[B]),
            .oc   (pay_reg[LDIV].o[C]),
            .db   (pay_reg[LDIV].d[B]),
            .dc   (pay_reg[LDIV].d[C]),
            .lob  (pay_reg[LDIV].lo[B]),
            .loc  (pay_reg[LDIV].lo[C]),
            .cand (cand_w[k])
        );
    end

    rcfs_pick u_pick (
        .clk      (clk),
        .en       (en),
        .cand     (cand_w),
        .sel_face (sel_face),
        .sel_hit  (sel_hit)
    );

    `RCFS_ASSERT_IMPL(a_nohit_face, out_valid && !hit, face == FACE_TOP, "miss must report top")
    `RCFS_ASSERT_IMPL(a_ready_stall, !in_ready, out_valid && !out_ready, "ready low without stall")
    `RCFS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(face) && $stable(hit), "held transaction changed")

endmodule

// ===== bench/tb_ray_cube_face_select_top.sv =====
`timescale 1ns / 1ps
module tb_ray_cube_face_select_top;
    import rcfs_pkg::*;

    localparam int       FB         = 16;
    localparam int       N_RANDOM   = 1150;
    localparam int       HOLD_AT    = 600;
    localparam int       TAIL       = 60;
    localparam longint   CYCLE_CAP  = 400000;
    localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic signed [31:0] dx, dy, dz;
        logic signed [15:0] cx, cy, cz;
    } ray_t;

    typedef struct {
        face_t face;
        logic  hit;
    } face_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [15:0] cell_x = '0, cell_y = '0, cell_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         face;
    logic               hit;

    ray_t      ray_q[$];
    face_res_t face_exp_q[$];
    int        sent_cnt = 0;
    int        recv_cnt = 0;
    int        hit_cnt = 0;
    int        err_cnt = 0;
    int        total_items = 0;
    longint    cycle_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    ray_cube_face_select_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .face(face), .hit(hit)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned sq_clip(longint x);
        longint unsigned m;
        m = (x < 0) ? longint'(-x) : longint'(x);
        if (m >= 64'h1_0000_0000)
            return ALL_ONES;
        return m * m;
    endfunction

    function automatic longint unsigned add_clip(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? ALL_ONES : s;
    endfunction

    function automatic longint slope_div(longint n, longint dv);
        longint unsigned un, ud, ip, mag;
        un = (n < 0) ? longint'(-n) : longint'(n);
        ud = (dv < 0) ? longint'(-dv) : longint'(dv);
        ip = un / ud;
        if (ip >= (64'd1 << (31 - FB)))
            mag = 64'h7FFF_FFFF;
        else
            mag = (ip << FB) + ((un % ud) << FB) / ud;
        return ((n < 0) != (dv < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic face_res_t nearest_face(ray_t r);
        longint o[3], d[3], lo[3], hi[3];
        longint plane, q, off, c;
        longint unsigned best, dist_sq;
        bit found, in_face;
        int a;
        face_res_t res;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        lo[0] = longint'(r.cx) <<< FB;
        lo[1] = longint'(r.cy) <<< FB;
        lo[2] = longint'(r.cz) <<< FB;
        found = 0;
        best = 0;
        res.face = FACE_TOP;
        for (int i = 0; i < 3; i++)
            hi[i] = lo[i] + (longint'(1) <<< FB);
        for (int k = 0; k < 6; k++)
        begin
            a = (k < 2) ? 1 : ((k < 4) ? 0 : 2);
            if (d[a] == 0)
                continue;
            plane = k[0] ? lo[a] : hi[a];
            q = slope_div(plane - o[a], d[a]);
            dist_sq = sq_clip(plane - o[a]);
            in_face = 1;
            for (int i = 0; i < 3; i++)
            begin
                if (i == a)
                    continue;
                off = (q * d[i]) >>> FB;
                c = o[i] + off;
                if (c < lo[i] || c > hi[i])
                    in_face = 0;
                dist_sq = add_clip(dist_sq, sq_clip(off));
            end
            if (!in_face || dist_sq == 0)
                continue;
            if (!found || dist_sq < best)
            begin
                found = 1;
                best = dist_sq;
                res.face = face_t'(k);
            end
        end
        res.hit = found;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return 0;
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    task automatic add_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz,
                           logic signed [15:0] cx, cy, cz);
        ray_t r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        r.cx = cx; r.cy = cy; r.cz = cz;
        ray_q = {ray_q, r};
    endtask

    task automatic report_mismatch(string what, logic [2:0] got_f, logic got_h,
                                   face_res_t want);
        err_cnt++;
        $display("ERROR t=%0t %s: got face=%0d hit=%0b want face=%0d hit=%0b",
                 $time, what, got_f, got_h, want.face, want.hit);
    endtask

    // driver
    always @(posedge clk)
    begin
        ray_t acc_ray;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                acc_ray = '{origin_x, origin_y, origin_z,
                            dir_x, dir_y, dir_z, cell_x, cell_y, cell_z};
                face_exp_q = {face_exp_q, nearest_face(acc_ray)};
                sent_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (ray_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct
                    && !(sent_cnt == HOLD_AT && face_exp_q.size() != 0))
                begin
                    origin_x <= ray_q[0].ox; origin_y <= ray_q[0].oy;
                    origin_z <= ray_q[0].oz;
                    dir_x <= ray_q[0].dx; dir_y <= ray_q[0].dy; dir_z <= ray_q[0].dz;
                    cell_x <= ray_q[0].cx; cell_y <= ray_q[0].cy; cell_z <= ray_q[0].cz;
                    void'(ray_q.pop_front());
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (face_exp_q.size() == 0)
                begin
                    err_cnt++;
                    $display("ERROR t=%0t unexpected transaction face=%0d hit=%0b",
                             $time, face, hit);
                end
                else
                begin
                    if (face !== face_exp_q[0].face)
                        report_mismatch("face", face, hit, face_exp_q[0]);
                    if (hit !== face_exp_q[0].hit)
                        report_mismatch("hit", face, hit, face_exp_q[0]);
                    if (face_exp_q[0].hit)
                        hit_cnt++;
                    void'(face_exp_q.pop_front());
                end
                recv_cnt++;
            end
            out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        case (sent_cnt * 4 / ((total_items == 0) ? 1 : total_items))
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic signed [15:0] cx, cy, cz;
        int base;
        // directed: axis rays into each face, zero dirs, extremes, origin on a face
        add_ray(32'sh0000_8000, 32'sh0005_0000, 32'sh0000_8000, 0, -32'sh1_0000, 0, 0, 0, 0);
        add_ray(32'sh0000_8000, -32'sh5_0000, 32'sh0000_8000, 0, 32'sh1_0000, 0, 0, 0, 0);
        add_ray(32'sh0005_0000, 32'sh0000_8000, 32'sh0000_8000, -32'sh1_0000, 0, 0, 0, 0, 0);
        add_ray(-32'sh5_0000, 32'sh0000_8000, 32'sh0000_8000, 32'sh1_0000, 0, 0, 0, 0, 0);
        add_ray(32'sh0000_8000, 32'sh0000_8000, 32'sh0005_0000, 0, 0, -32'sh1_0000, 0, 0, 0);
        add_ray(32'sh0000_8000, 32'sh0000_8000, -32'sh5_0000, 0, 0, 32'sh1_0000, 0, 0, 0);
        add_ray(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 0, 0, 0, 0, 0, 0);
        add_ray(32'sh0000_8000, 32'sh0001_0000, 32'sh0000_8000, 0, 32'sh1_0000, 0, 0, 0, 0);
        add_ray(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0, 0, 0);
        add_ray(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 1, 1, 1, 0, 0, 0);
        add_ray(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 1, 0, 0, 0, 0, 0);
        add_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                16'sh8000, 16'sh8000, 16'sh8000);
        add_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                -1, -1, -1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, -1, 32'sh7FFF_FFFF,
                16'sh8000, 16'sh7FFF, 0);
        add_ray(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        add_ray(32'sh0000_8000, -32'sh1_0000, 32'sh0000_8000,
                32'sh0000_4000, 32'sh1_0000, 0, 0, 0, 0);
        add_ray(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                -32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 0, 0, 0);
        add_ray(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
                -32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 0, 0, 0);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if ($urandom_range(0, 9) < 2)
                add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        16'($urandom), 16'($urandom), 16'($urandom));
            else
            begin
                cx = 16'($signed($urandom_range(0, 2000)) - 1000);
                cy = 16'($signed($urandom_range(0, 2000)) - 1000);
                cz = 16'($signed($urandom_range(0, 2000)) - 1000);
                base = $urandom_range(0, 1) ? 65536 : 4 * 65536;
                add_ray((int'(cx) <<< FB) + $signed($urandom_range(0, 2 * base)) - base + 32768,
                        (int'(cy) <<< FB) + $signed($urandom_range(0, 2 * base)) - base + 32768,
                        (int'(cz) <<< FB) + $signed($urandom_range(0, 2 * base)) - base + 32768,
                        rand_dir(), rand_dir(), rand_dir(), cx, cy, cz);
            end
        end
        total_items = ray_q.size();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (ray_q.size() != 0 || in_valid || face_exp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        $display("%0d rays sent, %0d face transactions checked, %0d with a hit",
                 sent_cnt, recv_cnt, hit_cnt);
        $display("phases: full rate, sparse input, output backpressure, light both");
        if (err_cnt == 0 && face_exp_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
